// ===== hw/rtl/ats_pkg.sv =====
package ats_pkg;

    localparam int DEF_MAX_TERMS = 32;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_DIV_W = 48;
    localparam int VAL_W = 24;
    localparam int CNT_W = 6;
    localparam int MODE_W = 2;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = -24'sh800000;
    localparam logic [MODE_W-1:0] MODE_SMALL = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEG = 2'd2;
    localparam longint PI_HALF_Q30 = 64'sd1686629713;

    typedef struct packed {
        logic signed [VAL_W-1:0] x_value;
        logic [CNT_W-1:0] term_count;
        logic [MODE_W-1:0] mode;
    } ats_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] result;
        logic overflow;
        logic divide_by_zero;
    } ats_out_t;

    // Job handed from the front end to the series engine.
    typedef struct packed {
        logic signed [VAL_W-1:0] x_value;
        logic [CNT_W:0] terms;
        logic [MODE_W-1:0] mode;
        logic skip;
        logic divide_by_zero;
    } ats_job_t;

endpackage

// ===== hw/rtl/arctan_taylor_series_unit.sv =====
// Each term is one pass of the shared divider; modes 1 and 2 first take the reciprocal of the
// input in one more pass. A job with nothing to sum goes from the queue straight to the strobe.
// Queueing: the engine takes the next queued item in the cycle after its strobe; busy is high
// only while the two-entry queue is full. The receiver cannot stall.
// Reset: rst_n asynchronous, active low, empties the queue and idles the engine.
module arctan_taylor_series_unit
    import ats_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS,
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  ats_in_t  operand,
    output logic     busy,
    output logic     done,
    output ats_out_t outcome
);

    ats_job_t wr_job, rd_job;
    logic push, full, pop, not_empty;

    ats_front #(.MAX_TERMS(MAX_TERMS)) u_front (
        .start(start), .operand(operand),
        .busy(busy), .push(push), .job(wr_job), .full(full)
    );

    ats_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .wr_job(wr_job), .full(full),
        .pop(pop), .not_empty(not_empty), .rd_job(rd_job)
    );

    ats_engine #(.FRAC_BITS(FRAC_BITS)) u_engine (
        .clk(clk), .rst_n(rst_n), .avail(not_empty), .job(rd_job),
        .pop(pop), .strobe(done), .res(outcome)
    );

endmodule

// ===== hw/rtl/ats_front.sv =====
module ats_front
    import ats_pkg::*;
#(
    parameter int MAX_TERMS = DEF_MAX_TERMS
)
(
    input  logic     start,
    input  ats_in_t  operand,
    output logic     busy,
    output logic     push,
    output ats_job_t job,
    input  logic     full
);

    logic [CNT_W:0] clamped;

    always_comb
    begin
        clamped = {1'b0, operand.term_count};
        if (clamped > (CNT_W+1)'(MAX_TERMS))
        begin
            clamped = (CNT_W+1)'(MAX_TERMS);
        end
        job.x_value = operand.x_value;
        job.terms = clamped;
        job.mode = operand.mode;
        job.divide_by_zero = (clamped != '0) && (operand.x_value == '0)
            && ((operand.mode == MODE_POS) || (operand.mode == MODE_NEG));
        job.skip = (clamped == '0) || job.divide_by_zero
            || !((operand.mode == MODE_SMALL) || (operand.mode == MODE_POS)
            || (operand.mode == MODE_NEG));
    end

    assign busy = full;
    assign push = start && !full;

endmodule

// ===== hw/rtl/ats_queue.sv =====
module ats_queue
    import ats_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  ats_job_t wr_job,
    output logic     full,
    input  logic     pop,
    output logic     not_empty,
    output ats_job_t rd_job
);

    ats_job_t mem_reg [2];
    logic [1:0] count_reg;
    logic wr_ptr_reg;
    logic rd_ptr_reg;

    assign full = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign rd_job = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== hw/rtl/ats_divider.sv =====
module ats_divider
    import ats_pkg::*;
#(
    parameter int NUM_W = DEF_DIV_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [NUM_W-1:0] numer,
    input  logic [23:0]      denom,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    // Restoring division, one quotient bit per cycle, numerator magnitude only.
    logic [NUM_W-1:0] q_reg;
    logic [24:0] r_reg;
    logic [23:0] d_reg;
    logic [6:0] cnt_reg;
    logic run_reg;
    logic [24:0] trial;

    assign trial = {r_reg[23:0], q_reg[NUM_W-1]} - {1'b0, d_reg};
    assign quot = q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done <= 1'b0;
            cnt_reg <= '0;
            q_reg <= '0;
            r_reg <= '0;
            d_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                q_reg <= numer;
                r_reg <= '0;
                d_reg <= denom;
                cnt_reg <= 7'(NUM_W);
            end
            else if (run_reg)
            begin
                if (!trial[24])
                begin
                    r_reg <= trial;
                    q_reg <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= {r_reg[23:0], q_reg[NUM_W-1]};
                    q_reg <= {q_reg[NUM_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    run_reg <= 1'b0;
                    done <= 1'b1;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/ats_engine.sv =====
module ats_engine
    import ats_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     avail,
    input  ats_job_t job,
    output logic     pop,
    output logic     strobe,
    output ats_out_t res
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RECIP = 4'd1;
    localparam logic [3:0] S_RWAIT = 4'd2;
    localparam logic [3:0] S_SQ = 4'd3;
    localparam logic [3:0] S_TERM = 4'd4;
    localparam logic [3:0] S_TWAIT = 4'd5;
    localparam logic [3:0] S_POW = 4'd6;
    localparam logic [3:0] S_FIN = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;

    // The reciprocal numerator 2^(2*FRAC_BITS) must fit the divider.
    localparam int DIV_W = (2 * FRAC_BITS + 1 > DEF_DIV_W) ? 2 * FRAC_BITS + 1 : DEF_DIV_W;

    localparam longint PH_TMP = (PI_HALF_Q30 <<< 1) >>> (30 - FRAC_BITS);
    localparam logic signed [VAL_W-1:0] PI_HALF = VAL_W'((PH_TMP + 1) >>> 1);

    logic [3:0] state_reg;
    ats_job_t job_reg;
    logic signed [VAL_W-1:0] a_reg, a2_reg, p_reg, s_reg, res_reg;
    logic a2_ovf_reg, ovf_reg;
    logic [CNT_W:0] i_reg;
    logic signed [47:0] prod_reg;
    logic neg_reg;

    logic div_go, div_done;
    logic [DIV_W-1:0] div_numer, div_quot;
    logic [23:0] div_denom;

    ats_divider #(.NUM_W(DIV_W)) u_div (
        .clk(clk), .rst_n(rst_n), .go(div_go), .numer(div_numer),
        .denom(div_denom), .done(div_done), .quot(div_quot)
    );

    logic signed [VAL_W-1:0] mul_b;
    logic signed [47:0] mul_p;
    logic signed [48:0] rnd;
    logic signed [48:0] shf;
    logic signed [VAL_W-1:0] sat_mul;
    logic mul_ovf;
    logic [CNT_W+1:0] odd;
    logic [23:0] a_mag;
    logic signed [DIV_W:0] qv;
    logic signed [VAL_W+1:0] sum_w;
    logic recip_ovf;
    logic signed [VAL_W-1:0] recip_sat;

    always_comb
    begin
        mul_b = (state_reg == S_SQ) ? a_reg : a2_reg;
        mul_p = ((state_reg == S_SQ) ? a_reg : p_reg) * mul_b;
        rnd = {prod_reg[47], prod_reg} + (49'sd1 <<< (FRAC_BITS - 1));
        shf = rnd >>> FRAC_BITS;
        mul_ovf = (shf > 49'(VAL_MAX)) || (shf < 49'(VAL_MIN));
        sat_mul = (shf > 49'(VAL_MAX)) ? VAL_MAX :
                  (shf < 49'(VAL_MIN)) ? VAL_MIN : shf[VAL_W-1:0];
        odd = {i_reg, 1'b1};
        a_mag = p_reg[VAL_W-1] ? 24'(-p_reg) : 24'(p_reg);
        div_go = 1'b0;
        div_numer = '0;
        div_denom = '0;
        if (state_reg == S_RECIP)
        begin
            div_go = 1'b1;
            a_mag = job_reg.x_value[VAL_W-1] ? 24'(-job_reg.x_value) : 24'(job_reg.x_value);
            div_numer = (DIV_W'(1) << (2 * FRAC_BITS)) + DIV_W'(a_mag[23:1]);
            div_denom = a_mag;
        end
        else if (state_reg == S_TERM)
        begin
            div_go = 1'b1;
            div_numer = DIV_W'(a_mag) + DIV_W'(odd[CNT_W+1:1]);
            div_denom = {16'd0, odd};
        end
        qv = neg_reg ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        recip_ovf = (qv > (DIV_W+1)'(VAL_MAX)) || (qv < (DIV_W+1)'(VAL_MIN));
        recip_sat = recip_ovf ? ((qv < 0) ? VAL_MIN : VAL_MAX) : $signed(qv[VAL_W-1:0]);
        sum_w = (i_reg[0]) ? ({{2{s_reg[VAL_W-1]}}, s_reg} - 26'(qv))
                           : ({{2{s_reg[VAL_W-1]}}, s_reg} + 26'(qv));
    end

    function automatic logic signed [VAL_W-1:0] sat26(input logic signed [VAL_W+1:0] v);
        if (v > 26'(VAL_MAX))
        begin
            return VAL_MAX;
        end
        if (v < 26'(VAL_MIN))
        begin
            return VAL_MIN;
        end
        return v[VAL_W-1:0];
    endfunction

    assign pop = (state_reg == S_IDLE) && avail;
    assign strobe = (state_reg == S_OUT);
    assign res = '{result: res_reg, overflow: ovf_reg,
                   divide_by_zero: job_reg.divide_by_zero};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg <= '0;
            a_reg <= '0; a2_reg <= '0; p_reg <= '0; s_reg <= '0; res_reg <= '0;
            a2_ovf_reg <= 1'b0; ovf_reg <= 1'b0; i_reg <= '0;
            prod_reg <= '0; neg_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (avail)
                    begin
                        job_reg <= job;
                        ovf_reg <= 1'b0;
                        s_reg <= '0;
                        i_reg <= '0;
                        res_reg <= '0;
                        a_reg <= job.x_value;
                        if (job.skip)
                        begin
                            state_reg <= S_OUT;
                        end
                        else if (job.mode == MODE_SMALL)
                        begin
                            state_reg <= S_SQ;
                            prod_reg <= job.x_value * job.x_value;
                        end
                        else
                        begin
                            state_reg <= S_RECIP;
                        end
                    end
                end
                S_RECIP:
                begin
                    neg_reg <= job_reg.x_value[VAL_W-1];
                    state_reg <= S_RWAIT;
                end
                S_RWAIT:
                begin
                    if (div_done)
                    begin
                        a_reg <= recip_sat;
                        ovf_reg <= ovf_reg | recip_ovf;
                        prod_reg <= recip_sat * recip_sat;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    // prod_reg holds a*a here.
                    a2_reg <= sat_mul;
                    a2_ovf_reg <= mul_ovf;
                    p_reg <= a_reg;
                    state_reg <= S_TERM;
                end
                S_TERM:
                begin
                    neg_reg <= p_reg[VAL_W-1];
                    state_reg <= S_TWAIT;
                end
                S_TWAIT:
                begin
                    if (div_done)
                    begin
                        s_reg <= sat26(sum_w);
                        ovf_reg <= ovf_reg | (sum_w > 26'(VAL_MAX)) | (sum_w < 26'(VAL_MIN));
                        i_reg <= i_reg + 1'b1;
                        if (i_reg + 1'b1 == job_reg.terms)
                        begin
                            state_reg <= S_FIN;
                        end
                        else
                        begin
                            prod_reg <= mul_p;
                            state_reg <= S_POW;
                        end
                    end
                end
                S_POW:
                begin
                    p_reg <= sat_mul;
                    ovf_reg <= ovf_reg | mul_ovf | a2_ovf_reg;
                    state_reg <= S_TERM;
                end
                S_FIN:
                begin
                    if (job_reg.mode == MODE_SMALL)
                    begin
                        res_reg <= s_reg;
                    end
                    else
                    begin
                        res_reg <= sat26((job_reg.mode == MODE_POS)
                            ? (26'(PI_HALF) - 26'(s_reg)) : (-26'(PI_HALF) - 26'(s_reg)));
                        ovf_reg <= ovf_reg | (sat26((job_reg.mode == MODE_POS)
                            ? (26'(PI_HALF) - 26'(s_reg)) : (-26'(PI_HALF) - 26'(s_reg)))
                            != ((job_reg.mode == MODE_POS) ? (PI_HALF - s_reg)
                            : (-PI_HALF - s_reg)));
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/ats_checker.sv =====
module ats_checker
    import ats_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     busy,
    input logic     done,
    input ats_out_t outcome
);

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && outcome.divide_by_zero |-> outcome.result == '0 && !outcome.overflow)
        else $error("divide flag with nonzero result");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({busy, done}))
        else $error("handshake outputs unknown");

endmodule

bind arctan_taylor_series_unit ats_checker u_ats_checker (.*);
